FILE: rtl/ile_pkg.sv
// Shared types and codes for the indexed list engine.
package ile_pkg;

  typedef enum logic [2:0] {
    KIND_READ = 3'd0,
    KIND_HEAD = 3'd1,
    KIND_TAIL = 3'd2,
    KIND_AT   = 3'd3,
    KIND_DEL  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_BAD_INDEX = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_READ = 2'd0,
    OP_INS  = 2'd1,
    OP_DEL  = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_POP,
    S_WALK,
    S_RDVAL,
    S_INSLINK,
    S_INSPREV,
    S_DELVIC,
    S_DELNEXT,
    S_DELHEAD,
    S_FINISH
  } seq_state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [11:0] index;
    logic signed [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic [10:0]        count;
  } out_beat_t;

  typedef struct packed {
    logic pop;
    logic push;
  } pool_cmd_t;

endpackage

FILE: rtl/indexed_list_engine_core.sv
// Indexed list engine: linked list of values in slot RAMs, walked from the head per request.
//
//   channel | direction | beat                          | handshake
//   in_     | input     | kind, index, value            | in_valid / in_stall
//   out_    | output    | read_value, status, count     | out_valid / out_stall
//
// One request at a time. A request touching position p walks the link RAM from
// the head, one link read per cycle, before it reads, links or unlinks there.
// Head inserts and head deletes do not walk; rejected requests go to the result.
// Reset is synchronous and needs no clearing pass; slot RAM contents are unused
// until written. A stalled result sits in the output register while the next
// request is already accepted and worked on.
module indexed_list_engine_core
  import ile_pkg::*;
#(
  parameter int CAPACITY   = 1024,
  parameter int VALUE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CW     = ((CNT_W > 11) ? CNT_W : 11) + 1;

  seq_state_t state_r, state_nxt;
  op_t        op_r, op_nxt;
  status_t    status_r, status_nxt;

  logic [SLOT_W-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     cur_r, cur_nxt;
  logic [CNT_W-1:0]      steps_r, steps_nxt;
  logic                  pending_r, pending_nxt;
  logic [SLOT_W-1:0]     new_slot_r, new_slot_nxt;
  logic [SLOT_W-1:0]     victim_r, victim_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [31:0]           rd_r, rd_nxt;
  out_beat_t             out_r, out_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Memory ports
  logic                  val_we;
  logic [SLOT_W-1:0]     val_waddr, val_raddr;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  link_we;
  logic [SLOT_W-1:0]     link_waddr, link_wdata, link_raddr, link_rdata;
  pool_cmd_t             pool_cmd;
  logic [SLOT_W-1:0]     push_slot, pop_slot;

  // Request decode
  logic              accept;
  logic              idx_neg;
  logic [CW-1:0]     idx_ext, cnt_ext;
  logic [CNT_W-1:0]  idx_pos;
  logic              in_range, full;
  logic [SLOT_W-1:0] eff;
  logic [63:0]       in_val_ext, rd_ext;
  logic [CW-1:0]     count_out_ext;

  assign accept     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign idx_neg    = in_data.index[11];
  assign idx_ext    = CW'(in_data.index[10:0]);
  assign cnt_ext    = CW'(count_r);
  assign idx_pos    = idx_ext[CNT_W-1:0];
  assign in_range   = !idx_neg && (idx_ext < cnt_ext);
  assign full       = (count_r >= CNT_W'(CAPACITY));
  assign in_val_ext = 64'(in_data.value);
  assign rd_ext     = 64'(signed'(val_rdata));

  // While walking, the link read of the previous step supplies the next slot.
  assign eff = pending_r ? link_rdata : cur_r;

  ile_ram #(
    .WIDTH(VALUE_BITS),
    .DEPTH(CAPACITY)
  ) u_values (
    .clk  (clk),
    .we   (val_we),
    .waddr(val_waddr),
    .wdata(val_r),
    .raddr(val_raddr),
    .rdata(val_rdata)
  );

  ile_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_links (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .raddr(link_raddr),
    .rdata(link_rdata)
  );

  ile_slot_pool #(
    .CAPACITY(CAPACITY)
  ) u_pool (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (pool_cmd),
    .push_slot(push_slot),
    .pop_slot (pop_slot)
  );

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    status_nxt   = status_r;
    head_nxt     = head_r;
    count_nxt    = count_r;
    cur_nxt      = cur_r;
    steps_nxt    = steps_r;
    pending_nxt  = pending_r;
    new_slot_nxt = new_slot_r;
    victim_nxt   = victim_r;
    val_nxt      = val_r;
    rd_nxt       = rd_r;
    val_we       = 1'b0;
    val_waddr    = new_slot_r;
    val_raddr    = eff;
    link_we      = 1'b0;
    link_waddr   = cur_r;
    link_wdata   = new_slot_r;
    link_raddr   = cur_r;
    pool_cmd     = '0;
    push_slot    = victim_r;

    case (state_r)
      S_IDLE: begin
        link_raddr = head_r;
        if (accept) begin
          status_nxt  = ST_DONE;
          rd_nxt      = '0;
          val_nxt     = in_val_ext[VALUE_BITS-1:0];
          cur_nxt     = head_r;
          pending_nxt = 1'b0;
          state_nxt   = S_FINISH;
          case (in_data.kind)
            KIND_READ: begin
              if (in_range) begin
                op_nxt    = OP_READ;
                steps_nxt = idx_pos;
                state_nxt = S_WALK;
              end else begin
                status_nxt = ST_BAD_INDEX;
              end
            end
            KIND_HEAD, KIND_TAIL: begin
              if (full) begin
                status_nxt = ST_FULL;
              end else begin
                op_nxt    = OP_INS;
                steps_nxt = (in_data.kind == KIND_HEAD) ? '0 : count_r;
                state_nxt = S_POP;
              end
            end
            KIND_AT: begin
              if (!idx_neg && (idx_ext > cnt_ext)) begin
                status_nxt = ST_BAD_INDEX;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else begin
                op_nxt    = OP_INS;
                steps_nxt = idx_neg ? '0 : idx_pos;
                state_nxt = S_POP;
              end
            end
            KIND_DEL: begin
              if (!in_range) begin
                status_nxt = ST_BAD_INDEX;
              end else if (idx_pos == '0) begin
                op_nxt    = OP_DEL;
                state_nxt = S_DELHEAD;
              end else begin
                op_nxt    = OP_DEL;
                steps_nxt = idx_pos - 1'b1;
                state_nxt = S_WALK;
              end
            end
            default: begin
              status_nxt = ST_BAD_INDEX;
            end
          endcase
        end
      end

      S_POP: begin
        new_slot_nxt = pop_slot;
        val_we       = 1'b1;
        val_waddr    = pop_slot;
        pool_cmd.pop = 1'b1;
        if (steps_r == '0) begin
          link_we    = 1'b1;
          link_waddr = pop_slot;
          link_wdata = head_r;
          head_nxt   = pop_slot;
          count_nxt  = count_r + 1'b1;
          state_nxt  = S_FINISH;
        end else begin
          steps_nxt   = steps_r - 1'b1;
          cur_nxt     = head_r;
          pending_nxt = 1'b0;
          state_nxt   = S_WALK;
        end
      end

      S_WALK: begin
        link_raddr = eff;
        cur_nxt    = eff;
        if (steps_r != '0) begin
          steps_nxt   = steps_r - 1'b1;
          pending_nxt = 1'b1;
        end else begin
          pending_nxt = 1'b0;
          case (op_r)
            OP_READ: state_nxt = S_RDVAL;
            OP_INS:  state_nxt = S_INSLINK;
            default: state_nxt = S_DELVIC;
          endcase
        end
      end

      S_RDVAL: begin
        rd_nxt    = rd_ext[31:0];
        state_nxt = S_FINISH;
      end

      S_INSLINK: begin
        link_we    = 1'b1;
        link_waddr = new_slot_r;
        link_wdata = link_rdata;
        state_nxt  = S_INSPREV;
      end

      S_INSPREV: begin
        link_we    = 1'b1;
        link_waddr = cur_r;
        link_wdata = new_slot_r;
        count_nxt  = count_r + 1'b1;
        state_nxt  = S_FINISH;
      end

      S_DELVIC: begin
        victim_nxt = link_rdata;
        link_raddr = link_rdata;
        state_nxt  = S_DELNEXT;
      end

      S_DELNEXT: begin
        link_we       = 1'b1;
        link_waddr    = cur_r;
        link_wdata    = link_rdata;
        pool_cmd.push = 1'b1;
        push_slot     = victim_r;
        count_nxt     = count_r - 1'b1;
        state_nxt     = S_FINISH;
      end

      S_DELHEAD: begin
        head_nxt      = link_rdata;
        pool_cmd.push = 1'b1;
        push_slot     = head_r;
        count_nxt     = count_r - 1'b1;
        state_nxt     = S_FINISH;
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register
  assign count_out_ext = CW'(count_r);

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if ((state_r == S_FINISH) && (!out_valid_r || !out_stall)) begin
      out_nxt.read_value = rd_r;
      out_nxt.status     = status_r;
      out_nxt.count      = count_out_ext[10:0];
      out_valid_nxt      = 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      pending_r   <= pending_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    status_r   <= status_nxt;
    cur_r      <= cur_nxt;
    steps_r    <= steps_nxt;
    new_slot_r <= new_slot_nxt;
    victim_r   <= victim_nxt;
    val_r      <= val_nxt;
    rd_r       <= rd_nxt;
    out_r      <= out_nxt;
  end

endmodule

FILE: rtl/ile_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ile_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/ile_slot_pool.sv
// Free-slot stack: a RAM of slot numbers plus a low-water mark for never-written positions.
module ile_slot_pool
  import ile_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pool_cmd_t                   cmd,
  input  logic [$clog2(CAPACITY)-1:0] push_slot,
  output logic [$clog2(CAPACITY)-1:0] pop_slot
);

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]  free_top_r, free_top_nxt;
  logic [CNT_W-1:0]  min_top_r, min_top_nxt;
  logic [CNT_W-1:0]  top_m1;
  logic              fresh;
  logic [SLOT_W-1:0] stack_rdata;

  // The stack is read at the top every cycle and the data is registered, so it is
  // ready in the cycle after the top last moved.
  assign top_m1   = free_top_r - 1'b1;
  // Positions below the lowest top ever reached were never written; their slot is the position itself.
  assign fresh    = top_m1 < min_top_r;
  assign pop_slot = fresh ? top_m1[SLOT_W-1:0] : stack_rdata;

  ile_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(CAPACITY)
  ) u_stack (
    .clk  (clk),
    .we   (cmd.push),
    .waddr(free_top_r[SLOT_W-1:0]),
    .wdata(push_slot),
    .raddr(top_m1[SLOT_W-1:0]),
    .rdata(stack_rdata)
  );

  always_comb begin
    free_top_nxt = free_top_r;
    min_top_nxt  = min_top_r;
    if (cmd.pop) begin
      free_top_nxt = top_m1;
      if (fresh) begin
        min_top_nxt = top_m1;
      end
    end else if (cmd.push) begin
      free_top_nxt = free_top_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_top_r <= CNT_W'(CAPACITY);
      min_top_r  <= CNT_W'(CAPACITY);
    end else begin
      free_top_r <= free_top_nxt;
      min_top_r  <= min_top_nxt;
    end
  end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the indexed list engine: directed table, then random traffic.
module tb;
  import ile_pkg::*;

  localparam int LIST_DEPTH   = 1024;
  localparam int STALL_PCT    = 9;
  localparam int HANG_LIMIT   = 20000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 64;

  // Request codes the block does not define; each one must be rejected.
  localparam logic [2:0] KIND_RSV5 = 3'd5;
  localparam logic [2:0] KIND_RSV6 = 3'd6;
  localparam logic [2:0] KIND_RSV7 = 3'd7;

  typedef struct packed {
    in_beat_t  req;
    bit        typed;
    out_beat_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [25] = '{
    '{'{KIND_READ, 12'sd0,     32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd0}},
    '{'{KIND_DEL,  12'sd0,     32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd0}},
    '{'{KIND_READ, -12'sd2048, 32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd0}},
    '{'{KIND_HEAD, 12'sd0,     32'sh7FFF_FFFF},   1'b1, '{32'sd0, ST_DONE, 11'd1}},
    '{'{KIND_TAIL, 12'sd0,     32'sh8000_0000},   1'b1, '{32'sd0, ST_DONE, 11'd2}},
    '{'{KIND_AT,   12'sd2047,  32'sd5},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd2}},
    '{'{KIND_AT,   12'sd3,     32'sd7},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd2}},
    '{'{KIND_AT,   12'sd2,     -32'sd1},          1'b1, '{32'sd0, ST_DONE, 11'd3}},
    '{'{KIND_AT,   -12'sd1,    32'sh5555_5555},   1'b1, '{32'sd0, ST_DONE, 11'd4}},
    '{'{KIND_AT,   -12'sd2048, 32'shAAAA_AAAA},   1'b1, '{32'sd0, ST_DONE, 11'd5}},
    '{'{KIND_AT,   12'sd2,     32'sh1234_5678},   1'b0, '0},
    '{'{KIND_READ, 12'sd0,     32'sd0},           1'b1, '{32'shAAAA_AAAA, ST_DONE, 11'd6}},
    '{'{KIND_READ, 12'sd5,     32'sd0},           1'b1, '{-32'sd1, ST_DONE, 11'd6}},
    '{'{KIND_READ, 12'sd6,     32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_READ, -12'sd1,    32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_READ, 12'sd2047,  -32'sd1},          1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_READ, 12'sd3,     32'sd0},           1'b0, '0},
    '{'{KIND_RSV5, 12'sd0,     32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_RSV6, 12'sd1,     32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_RSV7, -12'sd1,    -32'sd1},          1'b1, '{32'sd0, ST_BAD_INDEX, 11'd6}},
    '{'{KIND_DEL,  12'sd5,     32'sd0},           1'b0, '0},
    '{'{KIND_DEL,  12'sd2,     32'sd0},           1'b0, '0},
    '{'{KIND_DEL,  12'sd0,     32'sd0},           1'b0, '0},
    '{'{KIND_DEL,  -12'sd1,    32'sd0},           1'b1, '{32'sd0, ST_BAD_INDEX, 11'd3}},
    '{'{KIND_READ, 12'sd1,     32'sd0},           1'b0, '0}
  };

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  logic signed [31:0] list_vals[$];
  out_beat_t          pending_results[$];
  int                 mismatches  = 0;
  int                 idle_cycles = 0;
  bit                 quiet       = 1'b0;

  indexed_list_engine_core #(
    .CAPACITY  (LIST_DEPTH),
    .VALUE_BITS(32)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one request to the list copy and returns the result it must produce.
  function automatic out_beat_t apply_request(in_beat_t req);
    out_beat_t res;
    int        pos;
    int        n;
    res        = '0;
    res.status = ST_DONE;
    pos        = $signed(req.index);
    n          = list_vals.size();
    case (req.kind)
      KIND_READ: begin
        if (pos < 0 || pos >= n) res.status = ST_BAD_INDEX;
        else res.read_value = list_vals[pos];
      end
      KIND_HEAD, KIND_TAIL: begin
        if (n >= LIST_DEPTH) res.status = ST_FULL;
        else if (req.kind == KIND_HEAD) list_vals.push_front(req.value);
        else list_vals.push_back(req.value);
      end
      KIND_AT: begin
        // A position past the end is rejected even when the store is full.
        if (pos > n) res.status = ST_BAD_INDEX;
        else if (n >= LIST_DEPTH) res.status = ST_FULL;
        else if (pos <= 0) list_vals.push_front(req.value);
        else list_vals.insert(pos, req.value);
      end
      KIND_DEL: begin
        if (pos < 0 || pos >= n) res.status = ST_BAD_INDEX;
        else list_vals.delete(pos);
      end
      default: res.status = ST_BAD_INDEX;
    endcase
    res.count = 11'(list_vals.size());
    return res;
  endfunction

  // Mostly positions near the live range, with some noise over every kind and index bit.
  function automatic in_beat_t pick_request(int ins_pct);
    in_beat_t req;
    int       n;
    int       idx;
    n         = list_vals.size();
    req.value = $urandom;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(3))
        0:       req.value = 32'sh8000_0000;
        1:       req.value = 32'sh7FFF_FFFF;
        2:       req.value = 32'sd0;
        default: req.value = -32'sd1;
      endcase
    end
    if ($urandom_range(99) < 4) begin
      req.kind  = 3'($urandom);
      req.index = 12'($urandom);
    end else begin
      if ($urandom_range(99) < ins_pct) begin
        case ($urandom_range(2))
          0:       req.kind = KIND_HEAD;
          1:       req.kind = KIND_TAIL;
          default: req.kind = KIND_AT;
        endcase
      end else begin
        req.kind = $urandom_range(1) ? KIND_READ : KIND_DEL;
      end
      case ($urandom_range(9))
        0:       idx = -1 - int'($urandom_range(2047));
        1:       idx = n + 1 + int'($urandom_range(3));
        2:       idx = n;
        default: idx = int'($urandom_range(n));
      endcase
      req.index = 12'(idx);
    end
    return req;
  endfunction

  task automatic send_request(in_beat_t req, bit typed, out_beat_t want);
    out_beat_t predicted;
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(req);
    pending_results.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < STALL_PCT);
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result beat: read_value %0d status %0d count %0d",
               out_data.read_value, out_data.status, out_data.count);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, out_data.read_value);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.count !== want.count) begin
          $error("count: expected %0d, got %0d", want.count, out_data.count);
          mismatches++;
        end
      end
    end
  end

  // Ends a hung run: no beat on either channel for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i]) send_request(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);

    for (int i = 0; i < 400; i++) begin
      quiet = (i >= 120 && i < 200);
      send_request(pick_request(60), 1'b0, '0);
    end
    quiet = 1'b0;

    send_request(in_beat_t'{KIND_AT, 12'(LIST_DEPTH + 1), 32'sd9}, 1'b0, '0);
    send_request(in_beat_t'{KIND_AT, 12'(LIST_DEPTH), 32'sd9}, 1'b0, '0);
    send_request(in_beat_t'{KIND_AT, -12'sd5, 32'sd9}, 1'b0, '0);
    send_request(in_beat_t'{KIND_HEAD, 12'sd0, 32'sd9}, 1'b0, '0);
    send_request(in_beat_t'{KIND_TAIL, 12'sd0, 32'sd9}, 1'b0, '0);
    send_request(in_beat_t'{KIND_READ, 12'(LIST_DEPTH - 1), 32'sd0}, 1'b0, '0);
    send_request(in_beat_t'{KIND_READ, 12'(LIST_DEPTH), 32'sd0}, 1'b0, '0);
    send_request(in_beat_t'{KIND_DEL, 12'(LIST_DEPTH - 1), 32'sd0}, 1'b0, '0);
    send_request(in_beat_t'{KIND_TAIL, 12'sd0, -32'sd7}, 1'b0, '0);
    send_request(in_beat_t'{KIND_AT, 12'sd0, 32'sd9}, 1'b0, '0);

    repeat (30) send_request(pick_request(60), 1'b0, '0);
    repeat (120) send_request(pick_request(40), 1'b0, '0);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/ile_pkg.sv
rtl/ile_ram.sv
rtl/ile_slot_pool.sv
rtl/indexed_list_engine_core.sv
dv/tb.sv
